// File: hdl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ELEM_BITS_DEF = 32;

  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int ELEM_OUT_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Per-request result info handed from the pointer logic to the result stage
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
    logic                   use_elem;
  } req_info_t;

endpackage

// File: hdl/deq_mem.sv
module deq_mem
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [ELEM_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [ELEM_BITS-1:0] rd_data
);

  logic [ELEM_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [OP_W-1:0]      opcode,
  input  logic [VALUE_W-1:0]   push_value,
  input  logic [POS_W-1:0]     position,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [ELEM_BITS-1:0] wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output req_info_t            info
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          full, empty;
  logic [AW-1:0] front_dec, front_inc;
  logic [AW-1:0] back_slot, last_slot, pos_slot;
  logic [AW-1:0] cnt_lo, cnt_m1_lo, pos_lo;
  logic          do_wr, do_rd;
  logic [STATUS_W-1:0] status;

  // (front + offset) mod DEPTH, with both terms below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign cnt_lo    = AW'(cnt_r);
  assign cnt_m1_lo = AW'(cnt_r - CW'(1));
  assign pos_lo    = AW'(position);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = ring_add(front_r, AW'(1));
  assign back_slot = ring_add(front_r, cnt_lo);
  assign last_slot = ring_add(front_r, cnt_m1_lo);
  assign pos_slot  = ring_add(front_r, pos_lo);

  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    do_wr     = 1'b0;
    do_rd     = 1'b0;
    wr_addr   = front_dec;
    rd_addr   = front_r;
    status    = ST_OK;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_wr     = 1'b1;
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        wr_addr = back_slot;
        if (full) begin
          status = ST_FULL;
        end else begin
          do_wr   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd = 1'b1;
          if (opcode == OP_POP_FRONT) begin
            front_nxt = front_inc;
            cnt_nxt   = cnt_r - CW'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        rd_addr = last_slot;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd = 1'b1;
          if (opcode == OP_POP_BACK) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      OP_READ_INDEX: begin
        rd_addr = pos_slot;
        if (CMPW'(position) >= CMPW'(cnt_r)) begin
          status = ST_RANGE;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign wr_en         = accept && do_wr;
  assign rd_en         = accept && do_rd;
  assign wr_data       = ELEM_BITS'(push_value);
  assign info.status   = status;
  assign info.count    = COUNT_OUT_W'(cnt_nxt);
  assign info.use_elem = do_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hdl/deq_out.sv
module deq_out
  import deq_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  req_info_t              info,
  input  logic [ELEM_BITS-1:0]   rd_data,
  output logic                   stage_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ELEM_OUT_W-1:0]  out_elem_out,
  output logic [STATUS_W-1:0]    out_status,
  output logic [COUNT_OUT_W-1:0] out_count_out
);

  logic                   p_valid_r;
  req_info_t              p_info_r;
  logic                   p_move;
  logic                   out_valid_r;
  logic [ELEM_OUT_W-1:0]  out_elem_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  // Advance the pending request once the output register is free
  assign p_move     = p_valid_r && (!out_valid_r || out_ready);
  assign stage_free = !p_valid_r || p_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_info_r <= info;
    end
    if (p_move) begin
      out_elem_r   <= p_info_r.use_elem ? ELEM_OUT_W'(rd_data) : '0;
      out_status_r <= p_info_r.status;
      out_count_r  <= p_info_r.count;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_elem_out  = out_elem_r;
  assign out_status    = out_status_r;
  assign out_count_out = out_count_r;

endmodule

// File: hdl/indexed_deque.sv
// Channel  Direction  Handshake              Payload
// in_      request    in_valid / in_ready    in_opcode, in_push_value, in_position
// out_     result     out_valid / out_ready  out_elem_out, out_status, out_count_out
//
// One request per cycle is taken while in_ready is high; its result passes through the
// registered read of the slot memory and then the output register.
// Pointer and count update in the cycle of acceptance, so requests need no interlock.
// Synchronous reset clears front pointer, count and stage valids; slots are not cleared.
// A stalled result holds the pending request; in_ready drops until it moves on.
module indexed_deque
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_opcode,
  input  logic [VALUE_W-1:0]     in_push_value,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ELEM_OUT_W-1:0]  out_elem_out,
  output logic [STATUS_W-1:0]    out_status,
  output logic [COUNT_OUT_W-1:0] out_count_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 accept;
  logic                 stage_free;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [ELEM_BITS-1:0] wr_data, rd_data;
  req_info_t            info;

  assign in_ready = stage_free;
  assign accept   = in_valid && stage_free;

  deq_ctrl #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_opcode),
    .push_value (in_push_value),
    .position   (in_position),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .info       (info)
  );

  deq_mem #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_out #(
    .ELEM_BITS (ELEM_BITS)
  ) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .info          (info),
    .rd_data       (rd_data),
    .stage_free    (stage_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_elem_out  (out_elem_out),
    .out_status    (out_status),
    .out_count_out (out_count_out)
  );

endmodule

// File: dv/indexed_deque_tb.sv
module indexed_deque_tb;
  import deq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SW          = $clog2(DEPTH_DEF);

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } deq_request_t;

  typedef struct {
    logic [ELEM_OUT_W-1:0]  elem;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_opcode = '0;
  logic [VALUE_W-1:0] in_push_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ELEM_OUT_W-1:0] out_elem_out;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_OUT_W-1:0] out_count_out;

  // shadow copy of the deque
  logic [ELEM_BITS_DEF-1:0] ring_slots [DEPTH_DEF];
  logic [SW-1:0] head_slot = '0;
  int fill_level = 0;

  deq_request_t pending_requests [$];
  deq_result_t  expected_results [$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  indexed_deque DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_elem_out  (out_elem_out),
    .out_status    (out_status),
    .out_count_out (out_count_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SW-1:0] slot_at(int offset);
    return SW'((int'(head_slot) + offset) % DEPTH_DEF);
  endfunction

  task automatic predict_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos);
    deq_result_t r;
    r.elem = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_slot = slot_at(DEPTH_DEF - 1);
          ring_slots[head_slot] = value[ELEM_BITS_DEF-1:0];
          fill_level++;
        end else begin
          ring_slots[slot_at(fill_level)] = value[ELEM_BITS_DEF-1:0];
          fill_level++;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.elem = ring_slots[head_slot];
          if (op == OP_POP_FRONT) begin
            head_slot = slot_at(1);
            fill_level--;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.elem = ring_slots[slot_at(fill_level - 1)];
          if (op == OP_POP_BACK) fill_level--;
        end
      end
      OP_READ_INDEX: begin
        if (int'(pos) >= fill_level) r.status = ST_RANGE;
        else r.elem = ring_slots[slot_at(int'(pos))];
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = fill_level[COUNT_OUT_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic add_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] pos);
    deq_request_t q;
    q.op = op;
    q.value = value;
    q.pos = pos;
    pending_requests.push_back(q);
  endtask

  // runs of push-heavy, pop-heavy and mixed requests so the deque swings
  // between full and empty
  task automatic add_random_requests(input int n);
    int run_len;
    int bias;
    int roll;
    logic [OP_W-1:0] op;
    logic [VALUE_W-1:0] value;
    run_len = 0;
    bias = 0;
    for (int i = 0; i < n; i++) begin
      if (run_len == 0) begin
        bias = $urandom_range(2);
        run_len = $urandom_range(48, 20);
      end
      run_len--;
      roll = $urandom_range(99);
      case (bias)
        0: begin
          if (roll < 85) op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
          else op = OP_W'($urandom_range(OP_READ_INDEX, OP_POP_FRONT));
        end
        1: begin
          if (roll < 80) op = OP_W'($urandom_range(OP_PEEK_BACK, OP_POP_FRONT));
          else if (roll < 90) op = OP_READ_INDEX;
          else op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        default: op = OP_W'($urandom_range(OP_READ_INDEX, OP_PUSH_FRONT));
      endcase
      if ($urandom_range(99) < 3) op = OP_UNUSED;
      roll = $urandom_range(99);
      if (roll < 5) value = '0;
      else if (roll < 10) value = '1;
      else value = $urandom;
      add_request(op, value, POS_W'($urandom_range(15)));
    end
  endtask

  task automatic wait_all_done;
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    deq_request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_request(in_opcode, in_push_value, in_position);
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_push_value <= nxt.value;
          in_position <= nxt.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending: elem %h status %0d count %0d",
                 out_elem_out, out_status, out_count_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_elem_out !== want.elem) begin
            $error("out_elem_out: expected %h, got %h", want.elem, out_elem_out);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_count_out !== want.count) begin
            $error("out_count_out: expected %0d, got %0d", want.count, out_count_out);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        stall_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH_DEF; i++) ring_slots[SW'(i)] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 19;
    receiver_idle_pct = 73;
    // empty deque: every pop, peek and read misses, unused opcode is a no-op
    add_request(OP_POP_FRONT, 32'h0, 4'd0);
    add_request(OP_POP_BACK, 32'h0, 4'd0);
    add_request(OP_PEEK_FRONT, 32'h0, 4'd0);
    add_request(OP_PEEK_BACK, 32'h0, 4'd0);
    add_request(OP_READ_INDEX, 32'h0, 4'd0);
    add_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
    // front push wraps the head pointer below slot zero
    add_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd15);
    add_request(OP_PUSH_BACK, 32'h0000_0000, 4'd0);
    add_request(OP_PUSH_FRONT, 32'h8000_0001, 4'd0);
    add_request(OP_PEEK_FRONT, 32'h0, 4'd0);
    add_request(OP_PEEK_BACK, 32'h0, 4'd0);
    add_request(OP_READ_INDEX, 32'h0, 4'd0);
    add_request(OP_READ_INDEX, 32'h0, 4'd2);
    add_request(OP_READ_INDEX, 32'h0, 4'd3);
    add_request(OP_READ_INDEX, 32'h0, 4'd15);
    add_request(OP_UNUSED, 32'h0, 4'd0);
    add_request(OP_POP_BACK, 32'h0, 4'd0);
    add_request(OP_POP_FRONT, 32'h0, 4'd0);
    add_request(OP_POP_FRONT, 32'h0, 4'd0);
    add_request(OP_POP_FRONT, 32'h0, 4'd0);
    add_request(OP_PEEK_BACK, 32'h0, 4'd0);
    add_random_requests(320);
    wait_all_done();

    sender_idle_pct = 73;
    receiver_idle_pct = 19;
    add_random_requests(320);
    wait_all_done();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    // stall the result side while requests keep coming, so input backs up
    hold_requests = hold_requests + 1;
    add_random_requests(40);
    add_random_requests(320);
    wait_all_done();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
